FILE: sv/dmrb_pkg.sv
// shared types, constants and helpers for the delimited message ring buffer
`timescale 1ns / 1ps

package dmrb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int MAX_READ   = 64;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // request queue between front and back, depth is a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] DELIM_RESET = 8'd10;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_NO_MSG   = 2'd2,
        STS_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       start;
        logic [6:0] plen;
        logic [6:0] limit;
    } q_entry_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic       last;
        logic [8:0] len;
        logic       avail;
        logic [8:0] free;
    } result_t;

    function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] i);
        logic [ADDR_W-1:0] r;
        if (i == ADDR_W'(RING_DEPTH - 1))
            r = '0;
        else
            r = i + 1'b1;
        return r;
    endfunction

    function automatic logic [8:0] sat9(input logic [CNT_W-1:0] v);
        logic [8:0] r;
        if (32'(v) > 32'd511)
            r = 9'h1FF;
        else
            r = 9'(v);
        return r;
    endfunction

endpackage

FILE: sv/delimited_message_ring_buffer_unit.sv
// top level of the delimited message ring buffer
// push and flush: the request passes through the queue, then the result register
//   one request per cycle while the back is idle and the result is taken
// read and query: a scan of one byte per cycle up to the delimiter or the occupancy, then
//   a read streams one byte per cycle unless stalled, both set by the single ram read port
// delimiter write: recount of up to occupancy bytes, cfg_ready low meanwhile
// reset clears pointers, counts and queue, delimiter back to 10, ring contents undefined
`timescale 1ns / 1ps

module delimited_message_ring_buffer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_byte [7:0], packet_length [14:8], read_limit [21:15], zero fill
    input  logic [dmrb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command [1:0], packet_start [2]
    input  logic [dmrb_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_byte_out [7:0], message_length [16:8], free_space [25:17], zero fill
    output logic [dmrb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status [1:0], message_available [2]
    output logic [dmrb_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    // delimiter_byte
    input  logic [7:0]                      cfg_data
);
    import dmrb_pkg::*;

    // front to queue
    logic     q_push;
    logic     q_full;
    q_entry_t push_entry;

    // queue to back
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    // back result register
    logic     out_valid;
    result_t  out_res;

    // front: takes requests while the queue has room and decodes them
    dmrb_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    // queue: lets requests pile up while the back scans or streams
    dmrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .valid      (q_valid),
        .pop        (q_pop),
        .entry      (q_entry)
    );

    // back: ring ram, pointers, delimiter count and the result register
    dmrb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // result packing onto the master side
    assign m_axis_tvalid = out_valid;
    assign m_axis_tlast  = out_res.last;
    assign m_axis_tdata  = {6'd0, out_res.free, out_res.len, out_res.data};
    assign m_axis_tuser  = {out_res.avail, out_res.status};

    // error results are single items with no data byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_res.status != STS_OK) |-> out_res.last && (out_res.data == 8'd0))
        else $error("error result not a single empty item");

    // a message that is too long stays stored and has a length
    a_too_long_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_res.status == STS_TOO_LONG) |-> out_res.avail && (out_res.len != 9'd0))
        else $error("too long result without a stored message");

    // free space never exceeds the ring size
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_res.free) <= RING_DEPTH))
        else $error("free space above ring depth");

    // a delimiter write always starts a recount
    a_cfg_recount: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cfg_ready)
        else $error("delimiter write did not start a recount");

endmodule

FILE: sv/dmrb_front.sv
// request decode and limit clamp in front of the request queue
`timescale 1ns / 1ps

module dmrb_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // data_byte [7:0], packet_length [14:8], read_limit [21:15], zero fill
    input  logic [dmrb_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // command [1:0], packet_start [2]
    input  logic [dmrb_pkg::IN_USER_W-1:0] s_axis_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output dmrb_pkg::q_entry_t             q_entry
);
    import dmrb_pkg::*;

    logic [6:0] limit_raw;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign limit_raw     = s_axis_tdata[21:15];

    always_comb
    begin
        q_entry.cmd   = cmd_t'(s_axis_tuser[1:0]);
        q_entry.data  = s_axis_tdata[7:0];
        q_entry.start = s_axis_tuser[2];
        q_entry.plen  = s_axis_tdata[14:8];
        // fold the hard read cap into the reader limit
        if (32'(limit_raw) > MAX_READ)
            q_entry.limit = 7'(MAX_READ);
        else
            q_entry.limit = limit_raw;
    end

endmodule

FILE: sv/dmrb_queue.sv
// short request queue that decouples the front from the back
`timescale 1ns / 1ps

module dmrb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dmrb_pkg::q_entry_t push_entry,
    output logic               full,
    output logic               valid,
    input  logic               pop,
    output dmrb_pkg::q_entry_t entry
);
    import dmrb_pkg::*;

    q_entry_t          q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign entry   = q_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: sv/dmrb_back.sv
// ring store, pointers, message scan and result register
`timescale 1ns / 1ps

module dmrb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  dmrb_pkg::q_entry_t q_entry,
    output logic               q_pop,
    input  logic               cfg_valid,
    input  logic [7:0]         cfg_data,
    output logic               cfg_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output dmrb_pkg::result_t  out_res
);
    import dmrb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_EMIT    = 5'b00100,
        S_STREAM  = 5'b01000,
        S_RECOUNT = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic              drop_reg, drop_next;
    logic [7:0]        delim_reg, delim_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    cmd_t              wcmd_reg, wcmd_next;
    logic [6:0]        wlimit_reg, wlimit_next;
    logic [ADDR_W-1:0] iss_addr_reg, iss_addr_next;
    logic [CNT_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]  cmp_cnt_reg, cmp_cnt_next;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    status_t           sts_reg, sts_next;
    result_t           out_res_reg, out_res_next;

    logic [7:0]        ring_mem [RING_DEPTH];
    logic [7:0]        mem_q_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [7:0]        wr_data;

    logic [CNT_W-1:0]  free_now;
    logic              out_free;
    logic              hit, resolved;
    logic [CNT_W-1:0]  found_len;
    logic              drop_push, store_push;
    logic              stream_issue, out_move, stream_last;
    logic              load_out;

    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign free_now  = CNT_W'(RING_DEPTH) - occ_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign hit       = pend_reg && (mem_q_reg == delim_reg);
    assign found_len = hit ? cmp_cnt_reg + 1'b1 : '0;
    assign resolved  = hit || (!pend_reg && (cmp_cnt_reg == occ_reg));

    assign drop_push  = q_entry.start ? (16'(q_entry.plen) > 16'(free_now)) : drop_reg;
    assign store_push = !drop_push && (occ_reg != CNT_W'(RING_DEPTH));

    assign stream_issue = (iss_cnt_reg != len_reg) && (!pend_reg || out_free);
    assign out_move     = pend_reg && out_free;
    assign stream_last  = ((cmp_cnt_reg + 1'b1) == len_reg);

    always_comb
    begin
        state_next    = state_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        occ_next      = occ_reg;
        dcnt_next     = dcnt_reg;
        drop_next     = drop_reg;
        delim_next    = delim_reg;
        pend_next     = pend_reg;
        wcmd_next     = wcmd_reg;
        wlimit_next   = wlimit_reg;
        iss_addr_next = iss_addr_reg;
        iss_cnt_next  = iss_cnt_reg;
        cmp_cnt_next  = cmp_cnt_reg;
        hit_cnt_next  = hit_cnt_reg;
        len_next      = len_reg;
        sts_next      = sts_reg;
        out_res_next  = out_res_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = iss_addr_reg;
        wr_en         = 1'b0;
        wr_addr       = wp_reg;
        wr_data       = q_entry.data;
        load_out      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    delim_next    = cfg_data;
                    iss_addr_next = rp_reg;
                    iss_cnt_next  = '0;
                    cmp_cnt_next  = '0;
                    hit_cnt_next  = '0;
                    pend_next     = 1'b0;
                    state_next    = S_RECOUNT;
                end
                else if (q_valid)
                begin
                    case (q_entry.cmd)
                        CMD_PUSH:
                        begin
                            if (out_free)
                            begin
                                q_pop     = 1'b1;
                                drop_next = drop_push;
                                if (store_push)
                                begin
                                    wr_en    = 1'b1;
                                    wp_next  = next_idx(wp_reg);
                                    occ_next = occ_reg + 1'b1;
                                    if (q_entry.data == delim_reg)
                                        dcnt_next = dcnt_reg + 1'b1;
                                end
                                load_out            = 1'b1;
                                out_res_next.status = store_push ? STS_OK : STS_FULL;
                                out_res_next.data   = 8'd0;
                                out_res_next.last   = 1'b1;
                                out_res_next.len    = 9'd0;
                                out_res_next.avail  = (dcnt_next != '0);
                                out_res_next.free   = sat9(CNT_W'(RING_DEPTH) - occ_next);
                            end
                        end
                        CMD_FLUSH:
                        begin
                            if (out_free)
                            begin
                                q_pop               = 1'b1;
                                rp_next             = '0;
                                wp_next             = '0;
                                occ_next            = '0;
                                dcnt_next           = '0;
                                drop_next           = 1'b0;
                                load_out            = 1'b1;
                                out_res_next.status = STS_OK;
                                out_res_next.data   = 8'd0;
                                out_res_next.last   = 1'b1;
                                out_res_next.len    = 9'd0;
                                out_res_next.avail  = 1'b0;
                                out_res_next.free   = sat9(CNT_W'(RING_DEPTH));
                            end
                        end
                        CMD_READ, CMD_QUERY:
                        begin
                            q_pop         = 1'b1;
                            wcmd_next     = q_entry.cmd;
                            wlimit_next   = q_entry.limit;
                            iss_addr_next = rp_reg;
                            iss_cnt_next  = '0;
                            cmp_cnt_next  = '0;
                            pend_next     = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // one byte compared per cycle behind the registered ram read
                if (pend_reg)
                    cmp_cnt_next = cmp_cnt_reg + 1'b1;
                if (!hit && (iss_cnt_reg != occ_reg))
                begin
                    rd_en         = 1'b1;
                    rd_addr       = iss_addr_reg;
                    iss_addr_next = next_idx(iss_addr_reg);
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (resolved)
                begin
                    len_next = found_len;
                    if (wcmd_reg == CMD_QUERY)
                    begin
                        sts_next   = STS_OK;
                        state_next = S_EMIT;
                    end
                    else if (found_len == '0)
                    begin
                        sts_next   = STS_NO_MSG;
                        state_next = S_EMIT;
                    end
                    else if (16'(found_len) > 16'(wlimit_reg))
                    begin
                        sts_next   = STS_TOO_LONG;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // consume up front so each byte carries post-read status
                        occ_next     = occ_reg - found_len;
                        dcnt_next    = dcnt_reg - 1'b1;
                        iss_cnt_next = '0;
                        cmp_cnt_next = '0;
                        pend_next    = 1'b0;
                        state_next   = S_STREAM;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out            = 1'b1;
                    out_res_next.status = sts_reg;
                    out_res_next.data   = 8'd0;
                    out_res_next.last   = 1'b1;
                    out_res_next.len    = sat9(len_reg);
                    out_res_next.avail  = (dcnt_reg != '0);
                    out_res_next.free   = sat9(free_now);
                    state_next          = S_IDLE;
                end
            end

            S_STREAM:
            begin
                if (stream_issue)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = rp_reg;
                    rp_next      = next_idx(rp_reg);
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
                pend_next = stream_issue || (pend_reg && !out_free);
                if (out_move)
                begin
                    load_out            = 1'b1;
                    out_res_next.status = STS_OK;
                    out_res_next.data   = mem_q_reg;
                    out_res_next.last   = stream_last;
                    out_res_next.len    = sat9(len_reg);
                    out_res_next.avail  = (dcnt_reg != '0);
                    out_res_next.free   = sat9(free_now);
                    cmp_cnt_next        = cmp_cnt_reg + 1'b1;
                    if (stream_last)
                        state_next = S_IDLE;
                end
            end

            S_RECOUNT:
            begin
                if (pend_reg)
                begin
                    cmp_cnt_next = cmp_cnt_reg + 1'b1;
                    if (mem_q_reg == delim_reg)
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                end
                if (iss_cnt_reg != occ_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = iss_addr_reg;
                    iss_addr_next = next_idx(iss_addr_reg);
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && (cmp_cnt_reg == occ_reg))
                begin
                    dcnt_next  = hit_cnt_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            occ_reg       <= '0;
            dcnt_reg      <= '0;
            drop_reg      <= 1'b0;
            delim_reg     <= DELIM_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            occ_reg       <= occ_next;
            dcnt_reg      <= dcnt_next;
            drop_reg      <= drop_next;
            delim_reg     <= delim_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wcmd_reg     <= wcmd_next;
        wlimit_reg   <= wlimit_next;
        iss_addr_reg <= iss_addr_next;
        iss_cnt_reg  <= iss_cnt_next;
        cmp_cnt_reg  <= cmp_cnt_next;
        hit_cnt_reg  <= hit_cnt_next;
        len_reg      <= len_next;
        sts_reg      <= sts_next;
        out_res_reg  <= out_res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_q_reg <= ring_mem[rd_addr];
    end

endmodule
